/* hdl/usb_midi_event_packetizer_core_assert.svh */
// Assertion macros shared by the USB-MIDI event packetizer RTL.
// Needs nothing else. Each macro expands to one labeled concurrent assertion.
`ifndef USB_MIDI_EVENT_PACKETIZER_CORE_ASSERT_SVH
`define USB_MIDI_EVENT_PACKETIZER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UMEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define UMEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hdl/umep_pkg.sv */
// Shared types and constants of the USB-MIDI event packetizer.
// Used by umep_framer and usb_midi_event_packetizer_core; depends on nothing.
package umep_pkg;

    typedef enum logic [1:0] {
        OP_SHORT    = 2'd0,
        OP_SX_START = 2'd1,
        OP_SX_DATA  = 2'd2,
        OP_SX_END   = 2'd3
    } t_op;

    // Code index numbers used by system-exclusive packets.
    localparam logic [3:0] CIN_SX_CONT = 4'h4;
    localparam logic [3:0] CIN_SX_END1 = 4'h5;
    localparam logic [3:0] CIN_SX_END2 = 4'h6;
    localparam logic [3:0] CIN_SX_END3 = 4'h7;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    localparam logic [6:0] MAKER_ID_RST = 7'h41;
    localparam logic [6:0] COMMAND_RST  = 7'h12;

    // Register select is byte address bit 2.
    localparam logic REG_MAKER_ID = 1'b0;
    localparam logic REG_COMMAND  = 1'b1;

    typedef struct packed {
        t_op        op;
        logic [4:0] port;
        logic [1:0] msg_len;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
    } t_item;

    // Header in the low byte, so the struct is the output tdata as is.
    typedef struct packed {
        logic [7:0] midi_b3;
        logic [7:0] midi_b2;
        logic [7:0] midi_b1;
        logic [7:0] header_byte;
    } t_packet;

    typedef struct packed {
        logic [6:0] maker_id;
        logic [6:0] command;
    } t_cfg;

endpackage

/* hdl/umep_framer.sv */
// Packet builder and system-exclusive framing state of the packetizer.
// Depends on umep_pkg and usb_midi_event_packetizer_core_assert.svh.
`include "usb_midi_event_packetizer_core_assert.svh"

module umep_framer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  umep_pkg::t_item  i_item,
    input  umep_pkg::t_cfg   i_cfg,
    input  logic             i_advance,
    output logic             o_has_result,
    output umep_pkg::t_packet o_packet
);

    logic [1:0] r_held_count;
    logic [1:0] n_held_count;
    logic [3:0] r_sysex_cable;
    logic [3:0] n_sysex_cable;
    logic [7:0] r_held [2];
    logic       held_wr;
    logic [3:0] cable;

    // Cable is port minus one, wrapping within four bits.
    assign cable = i_item.port[3:0] - 4'd1;

    always_comb begin
        n_held_count  = r_held_count;
        n_sysex_cable = r_sysex_cable;
        held_wr       = 1'b0;
        o_has_result  = 1'b1;
        o_packet      = '0;
        unique case (i_item.op)
            umep_pkg::OP_SHORT: begin
                o_packet.header_byte = {cable, i_item.byte_a[7:4]};
                o_packet.midi_b1     = i_item.byte_a;
                o_packet.midi_b2     = i_item.msg_len[1] ? i_item.byte_b : 8'd0;
                o_packet.midi_b3     = (i_item.msg_len == 2'd3) ? i_item.byte_c : 8'd0;
            end
            umep_pkg::OP_SX_START: begin
                n_sysex_cable        = cable;
                n_held_count         = 2'd0;
                o_packet.header_byte = {cable, umep_pkg::CIN_SX_CONT};
                o_packet.midi_b1     = umep_pkg::SYSEX_START;
                o_packet.midi_b2     = {1'b0, i_cfg.maker_id};
                o_packet.midi_b3     = {1'b0, i_cfg.command};
            end
            umep_pkg::OP_SX_DATA: begin
                if (r_held_count[1]) begin
                    o_packet.header_byte = {r_sysex_cable, umep_pkg::CIN_SX_CONT};
                    o_packet.midi_b1     = r_held[0];
                    o_packet.midi_b2     = r_held[1];
                    o_packet.midi_b3     = i_item.byte_a;
                    n_held_count         = 2'd0;
                end else begin
                    o_has_result = 1'b0;
                    held_wr      = 1'b1;
                    n_held_count = r_held_count + 2'd1;
                end
            end
            umep_pkg::OP_SX_END: begin
                n_held_count = 2'd0;
                unique case (r_held_count)
                    2'd0: begin
                        o_packet.header_byte = {r_sysex_cable, umep_pkg::CIN_SX_END1};
                        o_packet.midi_b1     = umep_pkg::SYSEX_END;
                    end
                    2'd1: begin
                        o_packet.header_byte = {r_sysex_cable, umep_pkg::CIN_SX_END2};
                        o_packet.midi_b1     = r_held[0];
                        o_packet.midi_b2     = umep_pkg::SYSEX_END;
                    end
                    default: begin
                        o_packet.header_byte = {r_sysex_cable, umep_pkg::CIN_SX_END3};
                        o_packet.midi_b1     = r_held[0];
                        o_packet.midi_b2     = r_held[1];
                        o_packet.midi_b3     = umep_pkg::SYSEX_END;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count  <= 2'd0;
            r_sysex_cable <= 4'd0;
        end else if (i_advance) begin
            r_held_count  <= n_held_count;
            r_sysex_cable <= n_sysex_cable;
        end
    end

    // Held bytes are only read after they have been written.
    always_ff @(posedge i_clk) begin
        if (i_advance && held_wr) begin
            r_held[r_held_count[0]] <= i_item.byte_a;
        end
    end

    `UMEP_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_held_count != 2'd3)
    `UMEP_ASSERT_NOW(a_silent_only_on_data, i_clk, i_rst_n, !o_has_result,
        (i_item.op == umep_pkg::OP_SX_DATA) && !r_held_count[1])
    `UMEP_ASSERT_NEXT(a_hold_counts_up, i_clk, i_rst_n, i_advance && held_wr,
        r_held_count == $past(r_held_count) + 2'd1)

endmodule

/* hdl/usb_midi_event_packetizer_core.sv */
// Top level of the USB-MIDI event packetizer: input register, APB registers,
// framer and a two-entry output queue. Depends on umep_pkg, umep_framer and the assert header.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser op, tdata port/msg_len/byte_a..c
// m_*       out  m_tvalid/m_tready  tdata header_byte/midi_b1..b3
// APB       in   psel/penable       sysex_maker_id at 0x0, sysex_command at 0x4
//
// One item per cycle is accepted unless the input stalls; its packet is then queued.
// Rate is set by the single input register feeding the framer and the output queue.
// Synchronous active-low reset clears the framing state and empties both stages.
// A stalled sink fills the two-entry queue; the input stalls only once it is full
// and the waiting item would produce a packet.
`include "usb_midi_event_packetizer_core_assert.svh"

module usb_midi_event_packetizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // port[4:0], msg_len[6:5], byte_a[14:7],
                                   // byte_b[22:15], byte_c[30:23], zero [31]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // header_byte[7:0], midi_b1[15:8],
                                   // midi_b2[23:16], midi_b3[31:24]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               r_in_valid;
    umep_pkg::t_item    r_in;
    umep_pkg::t_item    in_item;
    umep_pkg::t_cfg     r_cfg;
    logic               has_result;
    umep_pkg::t_packet  packet;
    logic               move;
    logic               push;
    logic               pop;
    umep_pkg::t_packet  r_q [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == umep_pkg::REG_COMMAND) ? {25'd0, r_cfg.command}
                                                        : {25'd0, r_cfg.maker_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.maker_id <= umep_pkg::MAKER_ID_RST;
            r_cfg.command  <= umep_pkg::COMMAND_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                umep_pkg::REG_MAKER_ID: r_cfg.maker_id <= pwdata[6:0];
                umep_pkg::REG_COMMAND:  r_cfg.command  <= pwdata[6:0];
            endcase
        end
    end

    // Input register.
    assign in_item.op      = umep_pkg::t_op'(s_tuser);
    assign in_item.port    = s_tdata[4:0];
    assign in_item.msg_len = s_tdata[6:5];
    assign in_item.byte_a  = s_tdata[14:7];
    assign in_item.byte_b  = s_tdata[22:15];
    assign in_item.byte_c  = s_tdata[30:23];

    // An item leaves the input register unless its packet has nowhere to go.
    assign move     = r_in_valid && (!has_result || (r_count != 2'd2));
    assign s_tready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in <= in_item;
        end
    end

    umep_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .i_advance    (move),
        .o_has_result (has_result),
        .o_packet     (packet)
    );

    // Two-entry output queue.
    assign push     = move && has_result;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (r_count != 2'd0);
    assign m_tdata  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= packet;
        end
    end

    `UMEP_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `UMEP_ASSERT_NEXT(a_queue_grows, i_clk, i_rst_n, push && !pop,
        r_count == $past(r_count) + 2'd1)
    `UMEP_ASSERT_NOW(a_stall_reason, i_clk, i_rst_n, !s_tready,
        r_in_valid && has_result && (r_count == 2'd2))

endmodule
